// File: rtl/assert_macros.svh
// Assertion macros shared by the sprite decoder RTL.
// Included by every module that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/srld_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes of the sprite run-length decoder.
// Used by srld_div and the top level; depends on nothing else.
package srld_pkg;

  // Field widths.
  localparam int MAX_DIM_DEF = 4096;
  localparam int DIM_W       = 13;
  localparam int ORG_W       = 12;
  localparam int LEN_W       = 20;
  localparam int BYTE_W      = 8;
  localparam int SUM_W       = LEN_W + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  // Register reset values.
  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd64;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd64;

  // Header length-size code that is not defined.
  localparam logic [1:0] LEN_SIZE_BAD = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH      = 2'd0,
    CFG_HEIGHT     = 2'd1,
    CFG_ORIGIN_COL = 2'd2,
    CFG_ORIGIN_ROW = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_FILL    = 2'd0,
    KIND_LITERAL = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_BAD     = 2'd3
  } res_kind_t;

  typedef enum logic [1:0] {
    RK_LITERAL = 2'd0,
    RK_BAD     = 2'd1,
    RK_FILL    = 2'd2,
    RK_SKIP    = 2'd3
  } run_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_INDEX   = 3'd2,
    PH_LENGTH  = 3'd3,
    PH_LITERAL = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_ACCEPT = 3'd0,
    ST_STEP   = 3'd1,
    ST_ADV    = 3'd2,
    ST_DIV    = 3'd3,
    ST_END    = 3'd4,
    ST_EMIT   = 3'd5
  } ctl_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              start_image;
  } in_t;

  typedef struct packed {
    res_kind_t         kind;
    logic [DIM_W-1:0]  out_col;
    logic [DIM_W-1:0]  out_row;
    logic [LEN_W-1:0]  run_length;
    logic [BYTE_W-1:0] color_index;
    logic              last;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [DIM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [SUM_W-1:0] quot;
    logic [DIM_W-1:0] rem;
  } div_rsp_t;

endpackage

// File: rtl/srld_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the raster position advance.
// Depends on srld_pkg and assert_macros.svh.
`include "assert_macros.svh"
module srld_div (
  input  logic                clk,
  input  logic                rst_n,
  input  srld_pkg::div_req_t  req,
  output srld_pkg::div_rsp_t  rsp
);

  localparam int SW    = srld_pkg::SUM_W;
  localparam int DW    = srld_pkg::DIM_W;
  localparam int CNT_W = $clog2(SW);

  logic [SW-1:0]    quot_r, quot_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    divisor_r, divisor_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DW:0]      rem_sh;
  logic [DW:0]      diff;
  logic             fits;

  // Trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    rem_sh = {rem_r, quot_r[SW-1]};
    diff   = rem_sh - {1'b0, divisor_r};
    fits   = rem_sh >= {1'b0, divisor_r};
  end

  // Iteration control: load on start, then one bit per cycle.
  always_comb begin
    quot_nxt    = quot_r;
    rem_nxt     = rem_r;
    divisor_nxt = divisor_r;
    cnt_nxt     = cnt_r;
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    if (req.start) begin
      quot_nxt    = req.dividend;
      rem_nxt     = '0;
      divisor_nxt = req.divisor;
      cnt_nxt     = '0;
      busy_nxt    = 1'b1;
    end else if (busy_r) begin
      quot_nxt = {quot_r[SW-2:0], fits};
      rem_nxt  = fits ? diff[DW-1:0] : rem_sh[DW-1:0];
      cnt_nxt  = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(SW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r    <= quot_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

  `ASSERT_IMPLIES(a_rem_below_divisor, clk, rst_n, done_r, rem_r < divisor_r)
  `ASSERT_IMPLIES(a_busy_not_done, clk, rst_n, busy_r, !done_r)
  `ASSERT_NEXT(a_done_single, clk, rst_n, done_r, !done_r)
  `ASSERT_IMPLIES(a_cnt_bound, clk, rst_n, busy_r, cnt_r <= CNT_W'(SW - 1))

endmodule

// File: rtl/sprite_run_length_decoder_core.sv
`timescale 1ns / 1ps
// Sprite run-length decoder: top level with parser, sequencer and output register.
// Depends on srld_pkg, srld_div and assert_macros.svh.
//
// Usage: the sprite stream enters one byte per transaction on in_valid/in_ready
// (in_data.start_image marks a header that restarts the image). Results leave on
// out_valid/out_ready: fill-run descriptors, literal pixels, image-complete and
// bad-header markers, at most two per byte, the final one flagged by last.
// Configuration (width, height, origins) is written through cfg_wr_en, cfg_index
// and cfg_wdata while no transaction is in flight; writes take effect at once.
// Timing: a byte is handled by a small sequencer, one byte at a time. A byte
// that ends a fill or skip run past the row end needs the shared 21-step
// restoring divider for the position wrap; a literal pixel wraps without it.
// The next byte is accepted once the results of the current one are loaded in
// the output register, so one result may wait there while decoding goes on.
// When the receiver stalls, decoding stops at that point and nothing is lost.
// Reset: synchronous, active low; parsing returns to idle (bytes without
// start_image are dropped) and the registers take width 64, height 64, origin 0.
`include "assert_macros.svh"
module sprite_run_length_decoder_core #(
  parameter int MAX_DIM = srld_pkg::MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  srld_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output srld_pkg::out_t                      out_data,
  input  logic                                cfg_wr_en,
  input  logic [srld_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srld_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int DW = srld_pkg::DIM_W;
  localparam int OW = srld_pkg::ORG_W;
  localparam int LW = srld_pkg::LEN_W;
  localparam int BW = srld_pkg::BYTE_W;
  localparam int SW = srld_pkg::SUM_W;

  // Configuration registers.
  logic [DW-1:0] width_r, height_r;
  logic [OW-1:0] origin_col_r, origin_row_r;

  // Sequencer and parse state.
  srld_pkg::ctl_state_t state_r, state_nxt;
  srld_pkg::phase_t     phase_r, phase_nxt;
  srld_pkg::run_kind_t  kind_r, kind_nxt;
  logic [1:0]           left_r, left_nxt;
  logic [LW-1:0]        accum_r, accum_nxt;
  logic [BW-1:0]        fill_r, fill_nxt;
  logic [DW-1:0]        col_r, col_nxt;
  logic [DW-1:0]        row_r, row_nxt;
  logic [BW-1:0]        byte_r, byte_nxt;
  logic                 start_r, start_nxt;
  logic [LW-1:0]        adv_len_r, adv_len_nxt;
  logic                 end_go_r, end_go_nxt;

  // Pending results of the current byte and the output register.
  srld_pkg::out_t       res_r [2];
  srld_pkg::out_t       res_nxt [2];
  logic [1:0]           res_cnt_r, res_cnt_nxt;
  logic [1:0]           emit_idx_r, emit_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  srld_pkg::out_t       out_data_r, out_data_nxt;

  // Step decode results.
  srld_pkg::phase_t     st_phase;
  srld_pkg::run_kind_t  st_kind;
  logic [1:0]           st_left;
  logic [LW-1:0]        st_accum;
  logic [BW-1:0]        st_fill;
  logic [DW-1:0]        st_col, st_row;
  logic                 st_push;
  srld_pkg::out_t       st_res;
  logic                 st_adv;
  logic [LW-1:0]        st_len;
  logic                 st_end;
  logic                 hdr_go, fin_go;
  logic [LW-1:0]        fin_len, shifted, lit_left;

  // Misc datapath.
  logic [DW-1:0]        w_eff, h_eff;
  logic [DW-1:0]        pos_col, pos_row;
  logic [SW-1:0]        adv_sum;
  logic                 adv_fast, adv_wrap;
  logic [SW-1:0]        row_inc;
  logic [SW:0]          row_sum;
  logic [DW-1:0]        row_sat;
  logic                 out_free, emit_have, emit_load, emit_done;
  srld_pkg::div_req_t   div_req;
  srld_pkg::div_rsp_t   div_rsp;

  function automatic srld_pkg::out_t mk_res(input srld_pkg::res_kind_t k,
                                            input logic [DW-1:0] c,
                                            input logic [DW-1:0] r,
                                            input logic [LW-1:0] l,
                                            input logic [BW-1:0] ci);
    srld_pkg::out_t res;
    res.kind        = k;
    res.out_col     = c;
    res.out_row     = r;
    res.run_length  = l;
    res.color_index = ci;
    res.last        = 1'b0;
    return res;
  endfunction

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= srld_pkg::WIDTH_RST;
      height_r     <= srld_pkg::HEIGHT_RST;
      origin_col_r <= '0;
      origin_row_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        srld_pkg::CFG_WIDTH:      width_r      <= cfg_wdata[DW-1:0];
        srld_pkg::CFG_HEIGHT:     height_r     <= cfg_wdata[DW-1:0];
        srld_pkg::CFG_ORIGIN_COL: origin_col_r <= cfg_wdata[OW-1:0];
        srld_pkg::CFG_ORIGIN_ROW: origin_row_r <= cfg_wdata[OW-1:0];
        default: ;
      endcase
    end
  end

  // Effective dimensions: width at least one, both limited to MAX_DIM.
  always_comb begin
    if (width_r == '0) begin
      w_eff = DW'(1);
    end else if ({19'd0, width_r} > 32'(MAX_DIM)) begin
      w_eff = DW'(MAX_DIM);
    end else begin
      w_eff = width_r;
    end
    if ({19'd0, height_r} > 32'(MAX_DIM)) begin
      h_eff = DW'(MAX_DIM);
    end else begin
      h_eff = height_r;
    end
  end

  // Output position of the current raster point, flipped bottom-up.
  assign pos_col = col_r + {1'b0, origin_col_r};
  assign pos_row = {1'b0, origin_row_r} + h_eff - row_r - DW'(1);

  // Parse one byte: phase update and at most one immediate result.
  always_comb begin
    st_phase = phase_r;
    st_kind  = kind_r;
    st_left  = left_r;
    st_accum = accum_r;
    st_fill  = fill_r;
    st_col   = col_r;
    st_row   = row_r;
    st_push  = 1'b0;
    st_res   = '0;
    st_adv   = 1'b0;
    st_len   = accum_r;
    st_end   = 1'b0;
    hdr_go   = 1'b0;
    fin_go   = 1'b0;
    fin_len  = '0;
    shifted  = '0;
    lit_left = '0;
    if (start_r) begin
      st_col   = '0;
      st_row   = '0;
      st_accum = '0;
      st_left  = '0;
      if (h_eff == '0) begin
        st_phase = srld_pkg::PH_IDLE;
        st_push  = 1'b1;
        st_res   = mk_res(srld_pkg::KIND_DONE, '0, '0, '0, '0);
      end else begin
        hdr_go = 1'b1;
      end
    end else begin
      case (phase_r)
        srld_pkg::PH_HEADER: begin
          hdr_go = 1'b1;
        end
        srld_pkg::PH_INDEX: begin
          st_fill = byte_r;
          if (left_r != 2'd0) begin
            st_phase = srld_pkg::PH_LENGTH;
          end else begin
            fin_go  = 1'b1;
            fin_len = accum_r;
          end
        end
        srld_pkg::PH_LENGTH: begin
          shifted  = {accum_r[LW-BW-1:0], byte_r};
          st_accum = shifted;
          st_left  = left_r - 2'd1;
          if (left_r == 2'd1) begin
            fin_go  = 1'b1;
            fin_len = shifted;
          end
        end
        srld_pkg::PH_LITERAL: begin
          // Pixels past the last row are consumed without a result.
          if (row_r < h_eff) begin
            st_push = 1'b1;
            st_res  = mk_res(srld_pkg::KIND_LITERAL, pos_col, pos_row, LW'(1), byte_r);
            st_adv  = 1'b1;
            st_len  = LW'(1);
          end
          lit_left = accum_r - LW'(1);
          st_accum = lit_left;
          if (lit_left == '0) begin
            st_end = 1'b1;
          end
        end
        default: begin
          st_phase = srld_pkg::PH_IDLE;
        end
      endcase
    end

    // Header byte: run kind, length size and top length bits.
    if (hdr_go) begin
      if (byte_r[7:6] == srld_pkg::RK_BAD || byte_r[5:4] == srld_pkg::LEN_SIZE_BAD) begin
        st_phase = srld_pkg::PH_IDLE;
        st_push  = 1'b1;
        st_res   = mk_res(srld_pkg::KIND_BAD, '0, '0, '0, byte_r);
      end else begin
        st_kind  = srld_pkg::run_kind_t'(byte_r[7:6]);
        st_left  = byte_r[5:4];
        st_accum = {16'd0, byte_r[3:0]};
        if (st_kind == srld_pkg::RK_FILL) begin
          st_phase = srld_pkg::PH_INDEX;
        end else if (byte_r[5:4] != 2'd0) begin
          st_phase = srld_pkg::PH_LENGTH;
        end else begin
          fin_go  = 1'b1;
          fin_len = {16'd0, byte_r[3:0]};
        end
      end
    end

    // Run length complete.
    if (fin_go) begin
      if (st_kind == srld_pkg::RK_LITERAL) begin
        if (fin_len == '0) begin
          st_end = 1'b1;
        end else begin
          st_phase = srld_pkg::PH_LITERAL;
        end
      end else begin
        if (st_kind == srld_pkg::RK_FILL && fin_len != '0) begin
          st_push = 1'b1;
          st_res  = mk_res(srld_pkg::KIND_FILL, pos_col, pos_row, fin_len, st_fill);
        end
        st_adv = 1'b1;
        st_len = fin_len;
        st_end = 1'b1;
      end
    end
  end

  // Position advance: short cases directly, the rest through the divider.
  always_comb begin
    adv_sum  = {8'd0, col_r} + {1'b0, adv_len_r};
    adv_wrap = adv_sum == {8'd0, w_eff};
    adv_fast = adv_sum <= {8'd0, w_eff};
    row_inc  = (state_r == srld_pkg::ST_DIV) ? div_rsp.quot : SW'(1);
    row_sum  = {9'd0, row_r} + {1'b0, row_inc};
    row_sat  = (row_sum > {9'd0, h_eff}) ? h_eff : row_sum[DW-1:0];
  end

  // Output handshake helpers.
  always_comb begin
    out_free  = !out_valid_r || out_ready;
    emit_have = emit_idx_r != res_cnt_r;
    emit_load = (state_r == srld_pkg::ST_EMIT) && emit_have && out_free;
    emit_done = (state_r == srld_pkg::ST_EMIT) &&
                (!emit_have || (out_free && ((emit_idx_r + 2'd1) == res_cnt_r)));
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srld_pkg::ST_ACCEPT: begin
        if (in_valid) begin
          state_nxt = srld_pkg::ST_STEP;
        end
      end
      srld_pkg::ST_STEP: begin
        if (st_adv) begin
          state_nxt = srld_pkg::ST_ADV;
        end else if (st_end) begin
          state_nxt = srld_pkg::ST_END;
        end else begin
          state_nxt = srld_pkg::ST_EMIT;
        end
      end
      srld_pkg::ST_ADV: begin
        if (!adv_fast) begin
          state_nxt = srld_pkg::ST_DIV;
        end else if (end_go_r) begin
          state_nxt = srld_pkg::ST_END;
        end else begin
          state_nxt = srld_pkg::ST_EMIT;
        end
      end
      srld_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = end_go_r ? srld_pkg::ST_END : srld_pkg::ST_EMIT;
        end
      end
      srld_pkg::ST_END: begin
        state_nxt = srld_pkg::ST_EMIT;
      end
      srld_pkg::ST_EMIT: begin
        if (emit_done) begin
          state_nxt = srld_pkg::ST_ACCEPT;
        end
      end
      default: begin
        state_nxt = srld_pkg::ST_ACCEPT;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready         = state_r == srld_pkg::ST_ACCEPT;
    div_req.start    = (state_r == srld_pkg::ST_ADV) && !adv_fast;
    div_req.dividend = adv_sum;
    div_req.divisor  = w_eff;
  end

  // Datapath next values per sequencer step.
  always_comb begin
    phase_nxt    = phase_r;
    kind_nxt     = kind_r;
    left_nxt     = left_r;
    accum_nxt    = accum_r;
    fill_nxt     = fill_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    byte_nxt     = byte_r;
    start_nxt    = start_r;
    adv_len_nxt  = adv_len_r;
    end_go_nxt   = end_go_r;
    res_nxt      = res_r;
    res_cnt_nxt  = res_cnt_r;
    emit_idx_nxt = emit_idx_r;
    case (state_r)
      srld_pkg::ST_ACCEPT: begin
        if (in_valid) begin
          byte_nxt  = in_data.data_byte;
          start_nxt = in_data.start_image;
        end
      end
      srld_pkg::ST_STEP: begin
        phase_nxt   = st_phase;
        kind_nxt    = st_kind;
        left_nxt    = st_left;
        accum_nxt   = st_accum;
        fill_nxt    = st_fill;
        col_nxt     = st_col;
        row_nxt     = st_row;
        adv_len_nxt = st_len;
        end_go_nxt  = st_end;
        if (st_push) begin
          res_nxt[res_cnt_r[0]] = st_res;
          res_cnt_nxt           = res_cnt_r + 2'd1;
        end
      end
      srld_pkg::ST_ADV: begin
        if (adv_wrap) begin
          col_nxt = '0;
          row_nxt = row_sat;
        end else if (adv_fast) begin
          col_nxt = adv_sum[DW-1:0];
        end
      end
      srld_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          col_nxt = div_rsp.rem;
          row_nxt = row_sat;
        end
      end
      srld_pkg::ST_END: begin
        // Run finished: image complete once the row reaches the height.
        if (row_r >= h_eff) begin
          phase_nxt             = srld_pkg::PH_IDLE;
          res_nxt[res_cnt_r[0]] = mk_res(srld_pkg::KIND_DONE, '0, '0, '0, '0);
          res_cnt_nxt           = res_cnt_r + 2'd1;
        end else begin
          phase_nxt = srld_pkg::PH_HEADER;
        end
      end
      srld_pkg::ST_EMIT: begin
        if (emit_done) begin
          res_cnt_nxt  = '0;
          emit_idx_nxt = '0;
        end else if (emit_load) begin
          emit_idx_nxt = emit_idx_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // Output register: holds one result while decoding continues.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (emit_load) begin
      out_valid_nxt     = 1'b1;
      out_data_nxt      = res_r[emit_idx_r[0]];
      out_data_nxt.last = (emit_idx_r + 2'd1) == res_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srld_pkg::ST_ACCEPT;
      phase_r     <= srld_pkg::PH_IDLE;
      kind_r      <= srld_pkg::RK_LITERAL;
      left_r      <= '0;
      accum_r     <= '0;
      fill_r      <= '0;
      col_r       <= '0;
      row_r       <= '0;
      end_go_r    <= 1'b0;
      res_cnt_r   <= '0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      kind_r      <= kind_nxt;
      left_r      <= left_nxt;
      accum_r     <= accum_nxt;
      fill_r      <= fill_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      end_go_r    <= end_go_nxt;
      res_cnt_r   <= res_cnt_nxt;
      emit_idx_r  <= emit_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    start_r    <= start_nxt;
    adv_len_r  <= adv_len_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Shared divider for the position wrap.
  srld_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMPLIES(a_ready_no_pending, clk, rst_n, in_ready, res_cnt_r == 2'd0)
  `ASSERT_IMPLIES(a_div_in_flight, clk, rst_n, state_r == srld_pkg::ST_DIV, div_rsp.busy || div_rsp.done)
  `ASSERT_ALWAYS(a_emit_idx_bound, clk, rst_n, emit_idx_r <= res_cnt_r)
  `ASSERT_IMPLIES(a_load_when_free, clk, rst_n, emit_load, !out_valid_r || out_ready)

endmodule

// File: sim/sprite_run_length_decoder_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sprite run-length decoder core.
// Depends on srld_pkg and sprite_run_length_decoder_core; carries its own decoder predictor.
module sprite_run_length_decoder_core_tb;
  import srld_pkg::*;

  localparam int DIM_LIMIT     = MAX_DIM_DEF;
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_REPORTS   = 10;

  typedef enum logic [1:0] {
    RX_ALWAYS = 2'd0,
    RX_RANDOM = 2'd1,
    RX_BURSTY = 2'd2
  } rx_mode_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  sprite_run_length_decoder_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Decoder predictor: configuration copy, parser state and the pending results.
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]  geo_width;
  logic [DIM_W-1:0]  geo_height;
  logic [ORG_W-1:0]  geo_col_ofs;
  logic [ORG_W-1:0]  geo_row_ofs;

  phase_t            dec_phase;
  run_kind_t         dec_kind;
  logic [1:0]        len_left;
  logic [LEN_W-1:0]  len_acc;
  logic [BYTE_W-1:0] fill_idx;
  logic [ORG_W-1:0]  col_pos;
  logic [DIM_W-1:0]  row_pos;

  out_t              step_buf [2];
  int                step_n;
  out_t              pending_results [$];
  int                errors;

  function automatic int unsigned eff_width();
    if (geo_width == 0) return 1;
    if (geo_width > DIM_LIMIT) return DIM_LIMIT;
    return geo_width;
  endfunction

  function automatic int unsigned eff_height();
    if (geo_height > DIM_LIMIT) return DIM_LIMIT;
    return geo_height;
  endfunction

  function automatic void decoder_reset();
    geo_width   = WIDTH_RST;
    geo_height  = HEIGHT_RST;
    geo_col_ofs = '0;
    geo_row_ofs = '0;
    dec_phase   = PH_IDLE;
    dec_kind    = RK_LITERAL;
    len_left    = '0;
    len_acc     = '0;
    fill_idx    = '0;
    col_pos     = '0;
    row_pos     = '0;
  endfunction

  function automatic void add_result(res_kind_t k, int unsigned col, int unsigned row,
                                     int unsigned len, logic [BYTE_W-1:0] color);
    out_t r;
    r.kind        = k;
    r.out_col     = col[DIM_W-1:0];
    r.out_row     = row[DIM_W-1:0];
    r.run_length  = len[LEN_W-1:0];
    r.color_index = color;
    r.last        = 1'b0;
    if (step_n < 2) step_buf[step_n] = r;
    step_n++;
  endfunction

  // Result at the current raster position, flipped bottom-up, with the origin added.
  function automatic void add_positioned(res_kind_t k, int unsigned len,
                                         logic [BYTE_W-1:0] color);
    int unsigned col;
    int unsigned row;
    col = int'(col_pos) + int'(geo_col_ofs);
    row = int'(geo_row_ofs) + eff_height() - int'(row_pos) - 1;
    add_result(k, col, row, len, color);
  endfunction

  function automatic void advance_position(int unsigned len);
    int unsigned w;
    int unsigned h;
    int unsigned t;
    int unsigned r;
    w = eff_width();
    h = eff_height();
    t = int'(col_pos) + len;
    r = int'(row_pos) + t / w;
    col_pos = ORG_W'(t % w);
    if (r > h) r = h;
    row_pos = DIM_W'(r);
  endfunction

  function automatic void close_run();
    if (row_pos >= eff_height()) begin
      dec_phase = PH_IDLE;
      add_result(KIND_DONE, 0, 0, 0, 8'h00);
    end else begin
      dec_phase = PH_HEADER;
    end
  endfunction

  function automatic void length_complete();
    int unsigned len;
    len = len_acc;
    if (dec_kind == RK_LITERAL) begin
      if (len == 0) close_run();
      else dec_phase = PH_LITERAL;
      return;
    end
    if (dec_kind == RK_FILL && len != 0) add_positioned(KIND_FILL, len, fill_idx);
    advance_position(len);
    close_run();
  endfunction

  function automatic void parse_header(logic [BYTE_W-1:0] b);
    if (b[7:6] == RK_BAD || b[5:4] == LEN_SIZE_BAD) begin
      dec_phase = PH_IDLE;
      add_result(KIND_BAD, 0, 0, 0, b);
      return;
    end
    dec_kind = run_kind_t'(b[7:6]);
    len_left = b[5:4];
    len_acc  = {{(LEN_W-4){1'b0}}, b[3:0]};
    if (dec_kind == RK_FILL) begin
      dec_phase = PH_INDEX;
      return;
    end
    if (len_left != 0) begin
      dec_phase = PH_LENGTH;
      return;
    end
    length_complete();
  endfunction

  // Works out the results of one accepted byte and queues them.
  function automatic void predict_byte(logic [BYTE_W-1:0] b, logic start);
    step_n = 0;
    if (start) begin
      col_pos  = '0;
      row_pos  = '0;
      len_acc  = '0;
      len_left = '0;
      if (eff_height() == 0) begin
        dec_phase = PH_IDLE;
        add_result(KIND_DONE, 0, 0, 0, 8'h00);
      end else begin
        parse_header(b);
      end
    end else begin
      case (dec_phase)
        PH_HEADER: parse_header(b);
        PH_INDEX: begin
          fill_idx = b;
          if (len_left != 0) dec_phase = PH_LENGTH;
          else length_complete();
        end
        PH_LENGTH: begin
          len_acc  = {len_acc[LEN_W-9:0], b};
          len_left = len_left - 2'd1;
          if (len_left == 0) length_complete();
        end
        PH_LITERAL: begin
          if (row_pos < eff_height()) begin
            add_positioned(KIND_LITERAL, 1, b);
            advance_position(1);
          end
          len_acc = len_acc - 1'b1;
          if (len_acc == 0) close_run();
        end
        default: dec_phase = PH_IDLE;
      endcase
    end
    if (step_n > 0) step_buf[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n && i < 2; i++) pending_results.push_back(step_buf[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every result transaction against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: kind=%0d col=%0d row=%0d len=%0d color=%02h last=%0b",
                   out_data.kind, out_data.out_col, out_data.out_row,
                   out_data.run_length, out_data.color_index, out_data.last);
      end else begin
        want = pending_results.pop_front();
        if (out_data.kind !== want.kind || out_data.out_col !== want.out_col ||
            out_data.out_row !== want.out_row || out_data.run_length !== want.run_length ||
            out_data.color_index !== want.color_index || out_data.last !== want.last) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("mismatch expected: kind=%0d col=%0d row=%0d len=%0d color=%02h last=%0b",
                     want.kind, want.out_col, want.out_row, want.run_length,
                     want.color_index, want.last);
            $display("         actual:   kind=%0d col=%0d row=%0d len=%0d color=%02h last=%0b",
                     out_data.kind, out_data.out_col, out_data.out_row,
                     out_data.run_length, out_data.color_index, out_data.last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern chosen per test phase.
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode = RX_ALWAYS;
  int       rx_run  = 0;

  always @(posedge clk) begin
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_run == 0) begin
          rx_run    <= $urandom_range(1, 16);
          out_ready <= ~out_ready;
        end else begin
          rx_run <= rx_run - 1;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender helpers.
  // ---------------------------------------------------------------------------

  // Presents one byte, holds it until the transaction, then predicts it.
  // Valid is left high so that a following byte can go out back to back.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
    in_t item;
    item.data_byte   = b;
    item.start_image = start;
    in_valid <= 1'b1;
    in_data  <= item;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    predict_byte(b, start);
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles == 0) return;
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops sending and waits until every expected result has arrived and the
  // block has had time to finish a byte that gives no result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers on consecutive cycles; only called while drained.
  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                              input logic [CFG_DATA_W-1:0] col_ofs,
                              input logic [CFG_DATA_W-1:0] row_ofs);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    geo_width = w;
    cfg_index <= CFG_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    geo_height = h;
    cfg_index <= CFG_ORIGIN_COL;
    cfg_wdata <= col_ofs;
    @(posedge clk);
    geo_col_ofs = col_ofs[ORG_W-1:0];
    cfg_index <= CFG_ORIGIN_ROW;
    cfg_wdata <= row_ofs;
    @(posedge clk);
    geo_row_ofs = row_ofs[ORG_W-1:0];
    cfg_wr_en <= 1'b0;
  endtask

  // Random well-formed header; literal runs are kept short.
  function automatic logic [BYTE_W-1:0] random_header();
    int         r;
    logic [1:0] sz;
    logic [3:0] nib;
    r   = $urandom_range(0, 99);
    nib = $urandom_range(0, 15);
    sz  = $urandom_range(0, 2);
    if (r < 40) begin
      sz = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(1, 2)) : 2'd0;
      if (sz != 0) nib = 4'd0;
      return {RK_LITERAL, sz, nib};
    end
    if (r < 75) return {RK_FILL, sz, nib};
    return {RK_SKIP, sz, nib};
  endfunction

  // Header with a bad run kind or a bad length size.
  function automatic logic [BYTE_W-1:0] random_bad_header();
    logic [BYTE_W-1:0] b;
    b = $urandom_range(0, 255);
    if ($urandom_range(0, 1) != 0) b[7:6] = RK_BAD;
    else b[5:4] = LEN_SIZE_BAD;
    return b;
  endfunction

  // Picks the next byte from the parser phase: mostly well-formed sprites,
  // with restarts, bad headers and idle noise mixed in.
  function automatic in_t next_stream_item();
    in_t it;
    int  r;
    r = $urandom_range(0, 99);
    it.start_image = 1'b0;
    it.data_byte   = $urandom_range(0, 255);
    case (dec_phase)
      PH_IDLE: begin
        if (r < 90) begin
          it.start_image = 1'b1;
          it.data_byte   = random_header();
        end
      end
      PH_HEADER: begin
        if (r < 4) begin
          it.start_image = 1'b1;
          it.data_byte   = random_header();
        end else if (r < 8) begin
          it.data_byte = random_bad_header();
        end else begin
          it.data_byte = random_header();
        end
      end
      PH_LENGTH: begin
        if (dec_kind == RK_LITERAL && r >= 6)
          it.data_byte = (len_left > 1) ? 8'h00 : 8'($urandom_range(0, 24));
      end
      default: begin
        if (r < 2) begin
          it.start_image = 1'b1;
          it.data_byte   = random_header();
        end
      end
    endcase
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Test tasks.
  // ---------------------------------------------------------------------------

  // Bytes without a start while idle are dropped.
  task automatic test_idle_bytes();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // Short literal run with the extreme palette values.
  task automatic test_literal_run();
    send_byte(8'h02, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // Fill runs with 12-bit and 20-bit lengths; the longest one also completes
  // the image, so one byte gives two results.
  task automatic test_fill_runs();
    send_byte(8'h93, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h45, 1'b0);
    send_byte(8'hAF, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // Zero-length skip, fill and literal runs give nothing; a skip moves on.
  task automatic test_skip_and_empty_runs();
    send_byte(8'hC0, 1'b1);
    send_byte(8'hC7, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // Bad run kind and bad length size, at a start and in the middle of an image.
  task automatic test_bad_headers();
    send_byte(8'h40, 1'b1);
    send_byte(8'h30, 1'b1);
    send_byte(8'hC1, 1'b1);
    send_byte(8'h7F, 1'b0);
  endtask

  // A start byte in the middle of a literal run restarts at pixel zero.
  task automatic test_restart_mid_run();
    send_byte(8'h05, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h77, 1'b0);
  endtask

  // Tiny image at the largest origin: literal pixels past the last row are
  // dropped and the column reaches 4096, past the 12-bit origin. Then a zero height.
  task automatic test_small_image_edges();
    wait_drained();
    set_geometry(13'd2, 13'd1, 13'd4095, 13'd4095);
    send_byte(8'h03, 1'b1);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h30, 1'b0);
    wait_drained();
    set_geometry(13'd0, 13'd0, 13'd0, 13'd0);
    send_byte(8'h81, 1'b1);
  endtask

  // Random sprite streams under one geometry, with bursts, gaps and stalls.
  task automatic test_random_images(input logic [CFG_DATA_W-1:0] w,
                                    input logic [CFG_DATA_W-1:0] h,
                                    input logic [CFG_DATA_W-1:0] col_ofs,
                                    input logic [CFG_DATA_W-1:0] row_ofs,
                                    input int n_items, input bit pause_midway);
    in_t it;
    int  sent;
    int  burst_left;
    bit  gaps_on;
    bit  ignored;
    wait_drained();
    set_geometry(w, h, col_ofs, row_ofs);
    rx_mode    <= rx_mode_t'($urandom_range(0, 2));
    gaps_on    = ($urandom_range(0, 2) != 0);
    burst_left = $urandom_range(1, 12);
    sent       = 0;
    while (sent < n_items) begin
      it      = next_stream_item();
      ignored = (dec_phase == PH_IDLE) && !it.start_image;
      send_byte(it.data_byte, it.start_image);
      if (!ignored) sent++;
      if (pause_midway && sent >= n_items / 2) begin
        wait_drained();
        pause_midway = 1'b0;
      end
      burst_left--;
      if (burst_left <= 0) begin
        idle_gap(gaps_on ? $urandom_range(1, 6) : 0);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of tests and the final verdict.
  // ---------------------------------------------------------------------------
  initial begin
    errors = 0;
    decoder_reset();
    repeat (6) @(posedge clk);
    rst_n   <= 1'b1;
    rx_mode <= RX_RANDOM;
    @(posedge clk);

    test_idle_bytes();
    test_literal_run();
    test_fill_runs();
    test_skip_and_empty_runs();
    test_bad_headers();
    test_restart_mid_run();
    test_small_image_edges();

    test_random_images(13'd64, 13'd64, 13'd0, 13'd0, 90, 1'b0);
    test_random_images(13'd1, 13'd1, 13'd4095, 13'd4095, 90, 1'b0);
    test_random_images(13'd0, 13'd3, 13'd17, 13'h1FFF, 90, 1'b1);
    test_random_images(13'h1FFF, 13'h1FFF, 13'd4095, 13'd0, 90, 1'b0);
    test_random_images(13'd4096, 13'd4096, 13'd0, 13'd4095, 90, 1'b0);
    test_random_images(13'd5, 13'd7, 13'($urandom_range(0, 4095)),
                       13'($urandom_range(0, 4095)), 90, 1'b1);
    test_random_images(13'd13, 13'd2, 13'd4000, 13'd3, 90, 1'b0);
    test_random_images(13'd64, 13'd64, 13'd0, 13'd0, 90, 1'b0);

    wait_drained();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
